@@ rtl/core/smtc_pkg.sv @@
// Shared types and field widths for the subarray mean threshold counter.
`default_nettype none

package smtc_pkg;

    localparam int SAMPLE_W = 32;
    localparam int RUNS_W   = 11;
    localparam int TOTAL_W  = 20;

    // Control word that travels with each item down the cell chain.
    typedef struct packed {
        logic valid;   // slot holds an item
        logic start;   // item opened a new sequence
        logic skip;    // store was full: no write, no count
    } ctrl_t;

endpackage

`default_nettype wire

@@ rtl/core/smtc_cell.sv @@
// One chain cell: holds one stored prefix and counts it against the passing item.
`default_nettype none

module smtc_cell #(
    parameter int CELL_IDX = 0,
    parameter int IDX_W    = 10,
    parameter int CNT_W    = 11,
    parameter int PFX_W    = 43
) (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     en,
    input  smtc_pkg::ctrl_t         ctrl_i,
    input  wire [IDX_W-1:0]         idx_i,
    input  wire [CNT_W-1:0]         cnt_i,
    input  wire signed [PFX_W-1:0]  pre_i,
    input  wire signed [PFX_W-1:0]  newp_i,
    output smtc_pkg::ctrl_t         ctrl_o,
    output logic [IDX_W-1:0]        idx_o,
    output logic [CNT_W-1:0]        cnt_o,
    output logic signed [PFX_W-1:0] pre_o,
    output logic signed [PFX_W-1:0] newp_o
);

    smtc_pkg::ctrl_t         ctrl_reg;
    logic [IDX_W-1:0]        idx_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic [CNT_W-1:0]        cnt_next;
    logic signed [PFX_W-1:0] pre_reg;
    logic signed [PFX_W-1:0] newp_reg;
    logic signed [PFX_W-1:0] store_reg;
    logic signed [PFX_W-1:0] cmp_val;
    logic                    live;
    logic                    write_here;
    logic                    in_range;

    always_comb begin
        live       = ctrl_i.valid && !ctrl_i.skip;
        write_here = live && (idx_i == IDX_W'(CELL_IDX));
        // cells up to the item's own slot hold prefixes of its sequence
        in_range   = live && (IDX_W'(CELL_IDX) <= idx_i);
        cmp_val    = write_here ? pre_i : store_reg;
        cnt_next   = cnt_i + CNT_W'(in_range && (cmp_val <= newp_i));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg <= '0;
        end else if (en) begin
            ctrl_reg <= ctrl_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            idx_reg  <= idx_i;
            cnt_reg  <= cnt_next;
            pre_reg  <= pre_i;
            newp_reg <= newp_i;
            if (write_here) begin
                store_reg <= pre_i;
            end
        end
    end

    assign ctrl_o = ctrl_reg;
    assign idx_o  = idx_reg;
    assign cnt_o  = cnt_reg;
    assign pre_o  = pre_reg;
    assign newp_o = newp_reg;

endmodule

`default_nettype wire

@@ rtl/core/subarray_mean_threshold_counter.sv @@
// An accepted item passes the front-end register, the cell chain and the output register before its result appears.
// Throughput: one item per cycle; the whole cell chain advances in lockstep and
// stalls as a unit while the output register holds a result not yet taken.
// Reset (aresetn low, synchronous): threshold, prefix, fill count, total and
// overflow flag clear; chain slots empty. Stored prefixes need no clearing.
`default_nettype none

module subarray_mean_threshold_counter #(
    parameter int DEPTH = 1024
) (
    input  wire         aclk,
    input  wire         aresetn,
    // input items
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [31:0] s_tdata,   // [31:0] sample
    input  wire         s_tuser,   // start_sequence
    // result items
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [31:0] m_tdata,   // [10:0] runs_ending_here, [30:11] running_total, [31] 0
    output logic        m_tuser,   // overflow
    // register port
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    // |prefix| stays below DEPTH * 2^32
    localparam int PFX_W = 33 + $clog2(DEPTH);
    localparam logic REG_THRESHOLD = 1'b0;

    // ---------------- configuration ----------------
    logic signed [31:0] thr_reg;
    logic               cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_THRESHOLD) ? thr_reg : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= '0;
        end else if (cfg_wr && (paddr[2] == REG_THRESHOLD)) begin
            thr_reg <= pwdata;
        end
    end

    // ---------------- handshake ----------------
    logic en;
    logic accept;
    logic m_valid_reg;

    // the chain moves whenever the output register can take what leaves it
    assign en       = !m_valid_reg || m_tready;
    assign s_tready = en;
    assign accept   = s_tvalid && s_tready;

    // ---------------- front end: prefix and fill count ----------------
    logic [CNT_W-1:0]        fill_reg;
    logic [CNT_W-1:0]        fill_eff;
    logic signed [PFX_W-1:0] cur_reg;
    logic signed [PFX_W-1:0] cur_eff;
    logic signed [PFX_W-1:0] newp;
    logic                    ovf_reg;
    logic                    full;
    logic signed [31:0]      sample;

    smtc_pkg::ctrl_t         f_ctrl_reg;
    logic [IDX_W-1:0]        f_idx_reg;
    logic signed [PFX_W-1:0] f_pre_reg;
    logic signed [PFX_W-1:0] f_newp_reg;

    always_comb begin
        sample   = s_tdata;
        fill_eff = s_tuser ? '0 : fill_reg;
        cur_eff  = s_tuser ? '0 : cur_reg;
        full     = (!s_tuser && ovf_reg) || (fill_eff >= CNT_W'(DEPTH));
        newp     = cur_eff + PFX_W'(sample) - PFX_W'(thr_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg   <= '0;
            cur_reg    <= '0;
            ovf_reg    <= 1'b0;
            f_ctrl_reg <= '0;
        end else if (en) begin
            f_ctrl_reg.valid <= accept;
            f_ctrl_reg.start <= s_tuser;
            f_ctrl_reg.skip  <= full;
            if (accept) begin
                if (full) begin
                    // store full: only the flag changes (besides a start's clear)
                    fill_reg <= fill_eff;
                    cur_reg  <= cur_eff;
                    ovf_reg  <= 1'b1;
                end else begin
                    fill_reg <= fill_eff + CNT_W'(1);
                    cur_reg  <= newp;
                    ovf_reg  <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f_idx_reg  <= fill_eff[IDX_W-1:0];
            f_pre_reg  <= cur_eff;
            f_newp_reg <= newp;
        end
    end

    // ---------------- cell chain ----------------
    // Item k lands in cell idx; later items reach that cell only afterwards,
    // so every cell at or below an item's slot already holds its sequence.
    smtc_pkg::ctrl_t         ch_ctrl [DEPTH+1];
    logic [IDX_W-1:0]        ch_idx  [DEPTH+1];
    logic [CNT_W-1:0]        ch_cnt  [DEPTH+1];
    logic signed [PFX_W-1:0] ch_pre  [DEPTH+1];
    logic signed [PFX_W-1:0] ch_newp [DEPTH+1];

    assign ch_ctrl[0] = f_ctrl_reg;
    assign ch_idx[0]  = f_idx_reg;
    assign ch_cnt[0]  = '0;
    assign ch_pre[0]  = f_pre_reg;
    assign ch_newp[0] = f_newp_reg;

    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        smtc_cell #(
            .CELL_IDX (gi),
            .IDX_W    (IDX_W),
            .CNT_W    (CNT_W),
            .PFX_W    (PFX_W)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .ctrl_i  (ch_ctrl[gi]),
            .idx_i   (ch_idx[gi]),
            .cnt_i   (ch_cnt[gi]),
            .pre_i   (ch_pre[gi]),
            .newp_i  (ch_newp[gi]),
            .ctrl_o  (ch_ctrl[gi+1]),
            .idx_o   (ch_idx[gi+1]),
            .cnt_o   (ch_cnt[gi+1]),
            .pre_o   (ch_pre[gi+1]),
            .newp_o  (ch_newp[gi+1])
        );
    end

    // ---------------- output stage: running total ----------------
    smtc_pkg::ctrl_t                  tail;
    logic [CNT_W-1:0]                 tail_runs;
    logic [smtc_pkg::TOTAL_W-1:0]     total_reg;
    logic [smtc_pkg::TOTAL_W-1:0]     total_next;
    logic [smtc_pkg::RUNS_W-1:0]      m_runs_reg;
    logic [smtc_pkg::TOTAL_W-1:0]     m_total_reg;
    logic                             m_ovf_reg;

    always_comb begin
        tail       = ch_ctrl[DEPTH];
        tail_runs  = tail.skip ? '0 : ch_cnt[DEPTH];
        total_next = (tail.start ? '0 : total_reg) + smtc_pkg::TOTAL_W'(tail_runs);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= tail.valid;
            if (tail.valid) begin
                total_reg <= total_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en && tail.valid) begin
            m_runs_reg  <= smtc_pkg::RUNS_W'(tail_runs);
            m_total_reg <= total_next;
            m_ovf_reg   <= tail.skip;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_total_reg, m_runs_reg};
    assign m_tuser  = m_ovf_reg;

`ifndef SYNTHESIS
    // fill count never passes the store depth
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CNT_W'(DEPTH))
        else $error("fill count beyond store depth");

    // overflow flag holds until a start item clears it
    a_ovf_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        ovf_reg && !(accept && s_tuser) |=> ovf_reg)
        else $error("overflow flag dropped without a start");

    // an overflowed result counts no runs
    a_ovf_no_runs: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_ovf_reg |-> m_runs_reg == '0)
        else $error("runs reported on overflowed item");

    // a stalled result keeps its running total
    a_total_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_tready |=> $stable(total_reg))
        else $error("running total moved during stall");
`endif

endmodule

`default_nettype wire
